FILE: hw/rtl/ppmp6_pkg.sv
// ----------------------------------------------------------------------------
// ppmp6_pkg
// Shared types and constants of the PPM P6 stream parser.
// ----------------------------------------------------------------------------
package ppmp6_pkg;

	localparam int DIM_BITS_DEF = 16;
	localparam int MAXVAL_CAP   = 65536;
	localparam int WIDE_MIN     = 256;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [3:0] {
		PH_MAGIC = 4'd0,
		PH_CHK_W = 4'd1,
		PH_CMT_W = 4'd2,
		PH_NUM_W = 4'd3,
		PH_CHK_H = 4'd4,
		PH_CMT_H = 4'd5,
		PH_NUM_H = 4'd6,
		PH_CHK_M = 4'd7,
		PH_CMT_M = 4'd8,
		PH_NUM_M = 4'd9,
		PH_CHK_D = 4'd10,
		PH_CMT_D = 4'd11,
		PH_DATA  = 4'd12,
		PH_DONE  = 4'd13,
		PH_ERR   = 4'd14
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_MAGIC  = 2'd0,
		ERR_NO_WS  = 2'd1,
		ERR_NUMBER = 2'd2,
		ERR_MAXVAL = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		NUM_WIDTH  = 2'd0,
		NUM_HEIGHT = 2'd1,
		NUM_MAXVAL = 2'd2
	} num_sel_t;

	localparam logic [1:0] CH_BLUE = 2'd2;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] width;
		logic [15:0] height;
		logic        wide;
		logic [15:0] sample;
		logic [1:0]  chan;
		logic [15:0] col;
		logic [15:0] row;
		logic        last;
		err_t        err;
	} result_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

endpackage

FILE: hw/rtl/ppmp6_core.sv
// ----------------------------------------------------------------------------
// ppmp6_core
// Parser state and per-byte decode: header tokens, numbers, comments and
// pixel samples. One byte is consumed on each accept.
// ----------------------------------------------------------------------------
module ppmp6_core
	import ppmp6_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       start_of_file,
	output logic       res_valid,
	output result_t    res
);

	localparam int ACC_W = ((DIM_BITS > 16) ? DIM_BITS : 16) + 4;
	localparam logic [ACC_W-1:0] DIM_MAX = ACC_W'((64'd1 << DIM_BITS) - 64'd1);
	localparam logic [ACC_W-1:0] MAX_LIM = ACC_W'(MAXVAL_CAP - 1);
	localparam logic [ACC_W-1:0] CAP     = ACC_W'(MAXVAL_CAP);
	localparam logic [ACC_W-1:0] WIDE_LO = ACC_W'(WIDE_MIN);
	localparam logic [ACC_W-1:0] TEN     = ACC_W'(10);

	phase_t              phase_q,  phase_d,  e_phase;
	logic [1:0]          magic_q,  magic_d,  e_magic;
	logic [ACC_W-1:0]    acc_q,    acc_d,    e_acc;
	logic                seen_q,   seen_d,   e_seen;
	logic [DIM_BITS-1:0] w_q,      w_d,      e_w;
	logic [DIM_BITS-1:0] h_q,      h_d,      e_h;
	logic                two_q,    two_d,    e_two;
	logic [7:0]          hold_q,   hold_d,   e_hold;
	logic                half_q,   half_d,   e_half;
	logic [1:0]          chan_q,   chan_d,   e_chan;
	logic [DIM_BITS-1:0] col_q,    col_d,    e_col;
	logic [DIM_BITS-1:0] row_q,    row_d,    e_row;

	logic                is_digit;
	logic                ws;
	logic [ACC_W-1:0]    acc_mul;
	logic [ACC_W-1:0]    limit;
	num_sel_t            which;
	logic                do_num;
	logic                do_data;
	logic [15:0]         smp;
	logic [DIM_BITS-1:0] col_inc;
	logic [DIM_BITS-1:0] row_inc;
	logic [31:0]         w32, h32, c32, r32;
	logic                hdr_two;

	always_comb begin
		if (start_of_file) begin
			e_phase = PH_MAGIC;
			e_magic = '0;
			e_acc   = '0;
			e_seen  = 1'b0;
			e_w     = '0;
			e_h     = '0;
			e_two   = 1'b0;
			e_hold  = '0;
			e_half  = 1'b0;
			e_chan  = '0;
			e_col   = '0;
			e_row   = '0;
		end else begin
			e_phase = phase_q;
			e_magic = magic_q;
			e_acc   = acc_q;
			e_seen  = seen_q;
			e_w     = w_q;
			e_h     = h_q;
			e_two   = two_q;
			e_hold  = hold_q;
			e_half  = half_q;
			e_chan  = chan_q;
			e_col   = col_q;
			e_row   = row_q;
		end
	end

	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign ws       = is_ws(data_byte);
	assign acc_mul  = ACC_W'(e_acc * TEN) + ACC_W'(data_byte - CH_ZERO);
	assign col_inc  = e_col + 1'b1;
	assign row_inc  = e_row + 1'b1;
	assign w32      = 32'(e_w);
	assign h32      = 32'(e_h);
	assign c32      = 32'(e_col);
	assign r32      = 32'(e_row);
	assign smp      = e_two ? {e_hold, data_byte} : {8'h00, data_byte};
	assign hdr_two  = (e_acc >= WIDE_LO);

	always_comb begin
		unique case (e_phase)
			PH_CHK_H, PH_CMT_H, PH_NUM_H: which = NUM_HEIGHT;
			PH_CHK_M, PH_CMT_M, PH_NUM_M: which = NUM_MAXVAL;
			default:                      which = NUM_WIDTH;
		endcase
		limit = (which == NUM_MAXVAL) ? MAX_LIM : DIM_MAX;
	end

	always_comb begin
		phase_d   = e_phase;
		magic_d   = e_magic;
		acc_d     = e_acc;
		seen_d    = e_seen;
		w_d       = e_w;
		h_d       = e_h;
		two_d     = e_two;
		hold_d    = e_hold;
		half_d    = e_half;
		chan_d    = e_chan;
		col_d     = e_col;
		row_d     = e_row;
		res_valid = 1'b0;
		res       = '0;
		do_num    = 1'b0;
		do_data   = 1'b0;

		unique case (e_phase)
			PH_MAGIC: begin
				if (e_magic == 2'd0) begin
					if (!ws) begin
						if (data_byte != CH_P) begin
							phase_d   = PH_ERR;
							res_valid = 1'b1;
							res.kind  = KIND_ERROR;
							res.err   = ERR_MAGIC;
						end else begin
							magic_d = 2'd1;
						end
					end
				end else if (e_magic == 2'd1) begin
					if (data_byte != CH_SIX) begin
						phase_d   = PH_ERR;
						res_valid = 1'b1;
						res.kind  = KIND_ERROR;
						res.err   = ERR_MAGIC;
					end else begin
						magic_d = 2'd2;
					end
				end else if (!ws) begin
					phase_d   = PH_ERR;
					res_valid = 1'b1;
					res.kind  = KIND_ERROR;
					res.err   = ERR_NO_WS;
				end else begin
					phase_d = PH_CHK_W;
				end
			end
			PH_CHK_W, PH_CHK_H, PH_CHK_M: begin
				if (data_byte == CH_HASH) begin
					unique case (which)
						NUM_HEIGHT: phase_d = PH_CMT_H;
						NUM_MAXVAL: phase_d = PH_CMT_M;
						default:    phase_d = PH_CMT_W;
					endcase
				end else begin
					unique case (which)
						NUM_HEIGHT: phase_d = PH_NUM_H;
						NUM_MAXVAL: phase_d = PH_NUM_M;
						default:    phase_d = PH_NUM_W;
					endcase
					do_num = 1'b1;
				end
			end
			PH_CMT_W, PH_CMT_H, PH_CMT_M: begin
				if (data_byte == CH_LF) begin
					unique case (which)
						NUM_HEIGHT: phase_d = PH_NUM_H;
						NUM_MAXVAL: phase_d = PH_NUM_M;
						default:    phase_d = PH_NUM_W;
					endcase
				end
			end
			PH_NUM_W, PH_NUM_H, PH_NUM_M: do_num = 1'b1;
			PH_CHK_D: begin
				if (data_byte == CH_HASH) begin
					phase_d = PH_CMT_D;
				end else begin
					do_data = 1'b1;
				end
			end
			PH_CMT_D: begin
				if (data_byte == CH_LF) begin
					phase_d = ((e_w == '0) || (e_h == '0)) ? PH_DONE : PH_DATA;
				end
			end
			PH_DATA: do_data = 1'b1;
			default: ;
		endcase

		// decimal number byte
		if (do_num) begin
			if (is_digit) begin
				acc_d  = acc_mul;
				seen_d = 1'b1;
				if (acc_mul > limit) begin
					if (which != NUM_MAXVAL) begin
						phase_d   = PH_ERR;
						res_valid = 1'b1;
						res.kind  = KIND_ERROR;
						res.err   = ERR_NUMBER;
					end else begin
						acc_d = CAP;
					end
				end
			end else if (!ws) begin
				phase_d   = PH_ERR;
				res_valid = 1'b1;
				res.kind  = KIND_ERROR;
				res.err   = e_seen ? ERR_NO_WS : ERR_NUMBER;
			end else if (e_seen) begin
				seen_d = 1'b0;
				acc_d  = '0;
				unique case (which)
					NUM_WIDTH: begin
						w_d     = e_acc[DIM_BITS-1:0];
						phase_d = PH_CHK_H;
					end
					NUM_HEIGHT: begin
						h_d     = e_acc[DIM_BITS-1:0];
						phase_d = PH_CHK_M;
					end
					default: begin
						if ((e_acc == '0) || (e_acc >= CAP)) begin
							phase_d   = PH_ERR;
							res_valid = 1'b1;
							res.kind  = KIND_ERROR;
							res.err   = ERR_MAXVAL;
						end else begin
							two_d      = hdr_two;
							phase_d    = PH_CHK_D;
							res_valid  = 1'b1;
							res.kind   = KIND_HEADER;
							res.width  = w32[15:0];
							res.height = h32[15:0];
							res.wide   = hdr_two;
						end
					end
				endcase
			end
		end

		// image data byte
		if (do_data) begin
			if ((e_w == '0) || (e_h == '0)) begin
				phase_d = PH_DONE;
			end else begin
				phase_d = PH_DATA;
				if (e_two && !e_half) begin
					hold_d = data_byte;
					half_d = 1'b1;
				end else begin
					half_d     = 1'b0;
					res_valid  = 1'b1;
					res.kind   = KIND_SAMPLE;
					res.width  = w32[15:0];
					res.height = h32[15:0];
					res.wide   = e_two;
					res.sample = smp;
					res.chan   = e_chan;
					res.col    = c32[15:0];
					res.row    = r32[15:0];
					res.last   = (e_chan == CH_BLUE) && (col_inc == e_w) && (row_inc == e_h);
					if (e_chan == CH_BLUE) begin
						chan_d = '0;
						if (col_inc == e_w) begin
							col_d = '0;
							row_d = row_inc;
							if (row_inc == e_h) begin
								phase_d = PH_DONE;
							end
						end else begin
							col_d = col_inc;
						end
					end else begin
						chan_d = e_chan + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			magic_q <= '0;
			acc_q   <= '0;
			seen_q  <= 1'b0;
			w_q     <= '0;
			h_q     <= '0;
			two_q   <= 1'b0;
			hold_q  <= '0;
			half_q  <= 1'b0;
			chan_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			magic_q <= magic_d;
			acc_q   <= acc_d;
			seen_q  <= seen_d;
			w_q     <= w_d;
			h_q     <= h_d;
			two_q   <= two_d;
			hold_q  <= hold_d;
			half_q  <= half_d;
			chan_q  <= chan_d;
			col_q   <= col_d;
			row_q   <= row_d;
		end
	end

	// counters stay inside the image
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (col_q < w_q) && (row_q < h_q))
		else $error("pixel position outside image");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		chan_q != 2'd3)
		else $error("channel count overflow");

	a_half_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> two_q)
		else $error("byte half set in one-byte mode");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (phase_q == PH_ERR) && !start_of_file) |=> (phase_q == PH_ERR))
		else $error("error state left without file start");

endmodule

FILE: hw/rtl/ppm_p6_stream_parser_top.sv
// ----------------------------------------------------------------------------
// ppm_p6_stream_parser_top
// Binary PPM (P6) byte stream parser with header, sample and error results.
// ----------------------------------------------------------------------------
// a result is registered and valid in the cycle after its byte is accepted
// throughput: one byte per cycle, limited only by the single result register
// in_ready drops only while a result waits and out_ready is low
// reset: asynchronous, parser returns to the magic search, no result pending
// start_of_file clears the parser before its byte is decoded
module ppm_p6_stream_parser_top
	import ppmp6_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic        wide_samples,
	output logic [15:0] sample_value,
	output logic [1:0]  channel,
	output logic [15:0] pixel_column,
	output logic [15:0] pixel_row,
	output logic        last_of_image,
	output logic [1:0]  error_code
);

	logic    accept;
	logic    res_valid;
	result_t res;
	result_t res_q;
	logic    valid_q;

	assign in_ready = !valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	ppmp6_core #(
		.DIM_BITS (DIM_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.res_valid     (res_valid),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= accept && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid     = valid_q;
	assign result_kind   = res_q.kind;
	assign image_width   = res_q.width;
	assign image_height  = res_q.height;
	assign wide_samples  = res_q.wide;
	assign sample_value  = res_q.sample;
	assign channel       = res_q.chan;
	assign pixel_column  = res_q.col;
	assign pixel_row     = res_q.row;
	assign last_of_image = res_q.last;
	assign error_code    = res_q.err;

	a_kind_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_kind == KIND_HEADER) || (result_kind == KIND_SAMPLE) ||
			(result_kind == KIND_ERROR))
		else $error("bad result kind");

	a_last_blue: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_of_image) |-> (result_kind == KIND_SAMPLE) && (channel == CH_BLUE))
		else $error("last mark on non-blue item");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_kind == KIND_ERROR)) |->
			(sample_value == '0) && (image_width == '0) && !last_of_image)
		else $error("error item carries data");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(res_q))
		else $error("pending item lost");

endmodule

FILE: verif/tb_ppm_p6_stream_parser_top.sv
// ----------------------------------------------------------------------------
// tb_ppm_p6_stream_parser_top
// Drives PPM P6 files into the parser one byte per item. A built-in parser
// predicts every header, sample and error result, and a checker compares each
// result, field by field, with the oldest one still due. The files are
// directed headers and errors first, then random well-formed and damaged
// files, run under several idle and stall patterns and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ppm_p6_stream_parser_top;
	import ppmp6_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_TAIL     = 8;
	localparam int HOLD_LEN       = 400;

	typedef struct packed {
		logic       sof;
		logic [7:0] b;
	} file_byte_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte     = 8'h00;
	logic        start_of_file = 1'b0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic [1:0]  result_kind;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic        wide_samples;
	logic [15:0] sample_value;
	logic [1:0]  channel;
	logic [15:0] pixel_column;
	logic [15:0] pixel_row;
	logic        last_of_image;
	logic [1:0]  error_code;

	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int hold_cycles     = 0;
	int idle_cycles     = 0;
	int fail_count      = 0;
	bit hold_req        = 1'b0;
	bit hold_taken      = 1'b0;

	file_byte_t file_bytes[$];
	result_t    due_results[$];
	result_t    head;

	// parser state of the prediction
	phase_t      ph;
	logic [1:0]  magic_step;
	int unsigned num_acc;
	bit          got_digit;
	int unsigned img_w;
	int unsigned img_h;
	bit          wide_mode;
	logic [7:0]  hi_byte;
	bit          low_pending;
	logic [1:0]  chan_cnt;
	int unsigned col_cnt;
	int unsigned row_cnt;
	bit          err_hold;

	ppm_p6_stream_parser_top i_dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cycles <= HOLD_LEN;
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				$display("%0t: result kind expected none actual %0d", $time, result_kind);
				fail_count++;
			end else begin
				head = due_results.pop_front();
				compare_field("result_kind", head.kind, result_kind);
				compare_field("image_width", head.width, image_width);
				compare_field("image_height", head.height, image_height);
				compare_field("wide_samples", head.wide, wide_samples);
				compare_field("sample_value", head.sample, sample_value);
				compare_field("channel", head.chan, channel);
				compare_field("pixel_column", head.col, pixel_column);
				compare_field("pixel_row", head.row, pixel_row);
				compare_field("last_of_image", head.last, last_of_image);
				compare_field("error_code", head.err, error_code);
			end
		end
	end

	function automatic bit is_blank(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	task automatic clear_parser();
		ph = PH_MAGIC;
		magic_step = 2'd0;
		num_acc = 0;
		got_digit = 0;
		img_w = 0;
		img_h = 0;
		wide_mode = 0;
		hi_byte = 8'h00;
		low_pending = 0;
		chan_cnt = 2'd0;
		col_cnt = 0;
		row_cnt = 0;
		err_hold = 0;
	endtask

	task automatic flag_error(input err_t code);
		result_t r;
		ph = PH_ERR;
		err_hold = 1;
		r = '0;
		r.kind = KIND_ERROR;
		r.err = code;
		due_results.push_back(r);
	endtask

	task automatic emit_sample(input logic [15:0] value);
		result_t r;
		r = '0;
		r.kind = KIND_SAMPLE;
		r.width = img_w[15:0];
		r.height = img_h[15:0];
		r.wide = wide_mode;
		r.sample = value;
		r.chan = chan_cnt;
		r.col = col_cnt[15:0];
		r.row = row_cnt[15:0];
		r.last = (chan_cnt == CH_BLUE) && (col_cnt + 1 == img_w) && (row_cnt + 1 == img_h);
		due_results.push_back(r);
		if (chan_cnt == CH_BLUE) begin
			chan_cnt = 2'd0;
			col_cnt++;
			if (col_cnt >= img_w) begin
				col_cnt = 0;
				row_cnt++;
				if (row_cnt >= img_h)
					ph = PH_DONE;
			end
		end else begin
			chan_cnt++;
		end
	endtask

	task automatic take_pixel_byte(input logic [7:0] b);
		if (img_w == 0 || img_h == 0) begin
			ph = PH_DONE;
			return;
		end
		ph = PH_DATA;
		if (!wide_mode) begin
			emit_sample({8'h00, b});
		end else if (!low_pending) begin
			hi_byte = b;
			low_pending = 1;
		end else begin
			low_pending = 0;
			emit_sample({hi_byte, b});
		end
	endtask

	task automatic take_number_byte(input logic [7:0] b);
		int unsigned cap;
		result_t r;
		cap = (ph == PH_NUM_M) ? MAXVAL_CAP - 1 : (1 << DIM_BITS_DEF) - 1;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			num_acc = num_acc * 10 + (b - CH_ZERO);
			got_digit = 1;
			if (num_acc > cap) begin
				if (ph != PH_NUM_M)
					flag_error(ERR_NUMBER);
				else
					num_acc = MAXVAL_CAP;
			end
		end else if (!is_blank(b)) begin
			flag_error(got_digit ? ERR_NO_WS : ERR_NUMBER);
		end else if (got_digit) begin
			got_digit = 0;
			case (ph)
				PH_NUM_W: begin
					img_w = num_acc;
					ph = PH_CHK_H;
					num_acc = 0;
				end
				PH_NUM_H: begin
					img_h = num_acc;
					ph = PH_CHK_M;
					num_acc = 0;
				end
				default: begin
					if (num_acc == 0 || num_acc >= MAXVAL_CAP) begin
						flag_error(ERR_MAXVAL);
					end else begin
						wide_mode = (num_acc >= WIDE_MIN);
						ph = PH_CHK_D;
						num_acc = 0;
						r = '0;
						r.kind = KIND_HEADER;
						r.width = img_w[15:0];
						r.height = img_h[15:0];
						r.wide = wide_mode;
						due_results.push_back(r);
					end
				end
			endcase
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic sof);
		if (sof)
			clear_parser();
		if (err_hold)
			return;
		case (ph)
			PH_MAGIC: begin
				if (magic_step == 2'd0) begin
					if (!is_blank(b)) begin
						if (b != CH_P)
							flag_error(ERR_MAGIC);
						else
							magic_step = 2'd1;
					end
				end else if (magic_step == 2'd1) begin
					if (b != CH_SIX)
						flag_error(ERR_MAGIC);
					else
						magic_step = 2'd2;
				end else if (!is_blank(b)) begin
					flag_error(ERR_NO_WS);
				end else begin
					ph = PH_CHK_W;
				end
			end
			PH_CHK_W, PH_CHK_H, PH_CHK_M: begin
				if (b == CH_HASH) begin
					ph = phase_t'(ph + 1);
				end else begin
					ph = phase_t'(ph + 2);
					take_number_byte(b);
				end
			end
			PH_CMT_W, PH_CMT_H, PH_CMT_M: begin
				if (b == CH_LF)
					ph = phase_t'(ph + 1);
			end
			PH_NUM_W, PH_NUM_H, PH_NUM_M: take_number_byte(b);
			PH_CHK_D: begin
				if (b == CH_HASH)
					ph = PH_CMT_D;
				else
					take_pixel_byte(b);
			end
			PH_CMT_D: begin
				if (b == CH_LF)
					ph = (img_w == 0 || img_h == 0) ? PH_DONE : PH_DATA;
			end
			PH_DATA: take_pixel_byte(b);
			default: ;
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b, input logic sof);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		start_of_file <= sof;
		do @(posedge clk); while (!in_ready);
		parse_byte(b, sof);
	endtask

	task automatic flush_file();
		foreach (file_bytes[i])
			send_byte(file_bytes[i].b, file_bytes[i].sof);
		file_bytes.delete();
	endtask

	task automatic put(input logic [7:0] b);
		file_byte_t fb;
		fb.sof = (file_bytes.size() == 0);
		fb.b = b;
		file_bytes.push_back(fb);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	function automatic logic [7:0] blank_byte();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
	endfunction

	task automatic put_number(input int unsigned v);
		string s;
		repeat ($urandom_range(0, 1)) put(blank_byte());
		s = $sformatf("%0d", v);
		if ($urandom_range(99) < 5)
			s = {"0", s};
		put_text(s);
	endtask

	task automatic maybe_comment();
		int k;
		logic [7:0] c;
		k = $urandom_range(99);
		if (k < 20) begin
			put(CH_HASH);
			repeat ($urandom_range(0, 6)) begin
				c = 8'($urandom_range(255));
				put((c == CH_LF) ? CH_SPACE : c);
			end
			put(CH_LF);
			// a second comment is not allowed
			if (k < 2)
				put(CH_HASH);
		end
	endtask

	function automatic int unsigned pick_size();
		int k;
		k = $urandom_range(99);
		if (k < 6)
			return 0;
		if (k < 10)
			return 65535;
		if (k < 13)
			return $urandom_range(65536, 99999);
		return $urandom_range(1, 4);
	endfunction

	function automatic int unsigned pick_maxval();
		int k;
		k = $urandom_range(99);
		if (k < 5)
			return 0;
		if (k < 9)
			return $urandom_range(65536, 999999);
		if (k < 13)
			return 1;
		if (k < 17)
			return 255;
		if (k < 21)
			return 256;
		if (k < 25)
			return 65535;
		if (k < 60)
			return $urandom_range(2, 254);
		return $urandom_range(257, 65534);
	endfunction

	task automatic build_random_file();
		int unsigned w, h, mv, n;
		int k;
		k = $urandom_range(99);
		if (k < 4) begin
			repeat ($urandom_range(1, 12)) put(8'($urandom_range(255)));
			return;
		end
		repeat ($urandom_range(0, 2)) put(blank_byte());
		put(CH_P);
		put(CH_SIX);
		put(blank_byte());
		maybe_comment();
		w = pick_size();
		put_number(w);
		put(blank_byte());
		maybe_comment();
		h = pick_size();
		put_number(h);
		put(blank_byte());
		maybe_comment();
		mv = pick_maxval();
		put_number(mv);
		put(blank_byte());
		maybe_comment();
		if (w > 8 || h > 8)
			n = $urandom_range(1, 60);
		else
			n = w * h * 3 * ((mv >= WIDE_MIN) ? 2 : 1);
		if ($urandom_range(99) < 10)
			n += $urandom_range(1, 4);
		if ($urandom_range(99) < 5)
			n = $urandom_range(0, n);
		repeat (n) put(8'($urandom_range(255)));
		if ($urandom_range(99) < 10)
			file_bytes[$urandom_range(0, file_bytes.size() - 1)].b = 8'($urandom_range(255));
	endtask

	task automatic test_header_extremes();
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		// widest maxval, comment right before the pixel data
		put_text("P6\n1 1 65535\n#\n");
		put(8'h00);
		put(8'h00);
		put(8'hFF);
		put(8'hFF);
		put(8'h12);
		put(8'h34);
		flush_file();
		// empty image, trailing byte ignored
		put_text("P6 0 9 1 Z");
		flush_file();
	endtask

	task automatic test_error_codes();
		put(8'hFF);
		put(CH_P);
		flush_file();
		put_text("P7");
		flush_file();
		put_text("P6P");
		flush_file();
		put_text("P6 #\n#");
		flush_file();
		put_text("P6 65536");
		flush_file();
		put_text("P6 1 1 0 ");
		flush_file();
		put_text("P6 1 1 65536 ");
		flush_file();
		put_text("P6 12x");
		flush_file();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
		int sent;
		sender_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < count) begin
			build_random_file();
			sent += file_bytes.size();
			flush_file();
		end
	endtask

	task automatic test_output_backpressure();
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req <= 1'b1;
		put_text("P6 4 4 255\n");
		repeat (48) put(8'($urandom_range(255)));
		flush_file();
	endtask

	initial begin
		clear_parser();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_extremes();
		test_error_codes();
		test_random_traffic(0, 0, 250);
		test_random_traffic(81, 0, 250);
		test_output_backpressure();
		test_random_traffic(0, 81, 250);
		test_random_traffic(12, 12, 250);
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/ppmp6_pkg.sv
hw/rtl/ppmp6_core.sv
hw/rtl/ppm_p6_stream_parser_top.sv
verif/tb_ppm_p6_stream_parser_top.sv
